// File: rtl/vwbf_pkg.sv
// Shared constants, opcodes and bit helpers for the variable-width bit FIFO.
package vwbf_pkg;

  localparam int RING_WORDS  = 64;
  localparam int ADDR_W      = (RING_WORDS > 1) ? $clog2(RING_WORDS) : 1;
  localparam int COUNT_W     = $clog2(RING_WORDS + 1);
  localparam int HELD_W      = COUNT_W + 6;
  localparam int BITS_HELD_W = 12;
  localparam int WORD_W      = 32;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [HELD_W-1:0]  held_t;
  typedef logic [WORD_W-1:0]  word_t;

  typedef enum logic [2:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_PEEK  = 3'd2,
    OP_CLEAR = 3'd3,
    OP_PAD   = 3'd4
  } op_t;

  // Mask of the n lowest bits; n of 32 or more gives all ones.
  function automatic word_t low_mask(input logic [5:0] n);
    word_t m;
    if (n >= 6'd32) begin
      m = '1;
    end else begin
      m = (word_t'(1) << n) - word_t'(1);
    end
    return m;
  endfunction

  function automatic word_t shl32(input word_t v, input logic [5:0] n);
    return (n >= 6'd32) ? '0 : (v << n);
  endfunction

  function automatic word_t shr32(input word_t v, input logic [5:0] n);
    return (n >= 6'd32) ? '0 : (v >> n);
  endfunction

  function automatic addr_t ring_next(input addr_t a);
    return (a == addr_t'(RING_WORDS - 1)) ? '0 : a + addr_t'(1);
  endfunction

endpackage

// File: rtl/vwbf_ram.sv
// Simple dual-port word RAM with a registered read port.
module vwbf_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/variable_width_bit_fifo_top.sv
// Top level of the variable-width bit FIFO: control, front/back words and ring RAM.
//
// Usage: drive opcode, push_data and bit_count and raise start while busy is
// low; the beat is taken at that clock edge. Opcodes are push (append up to
// 32 bits), pop, peek (read up to 32 bits, first bit at bit zero), clear and
// pad (zero-fill the back word to a byte boundary).
// The accept cycle issues the read of the oldest ring word; the next cycle
// (busy high) works out the operation and writes back a completed word, and
// in the cycle after that done pulses for one cycle with read_data, ok and
// bits_held. A new beat may be accepted in the done cycle, but not while
// busy is high, as the operation waits on the registered read port of the
// ring RAM.
// The ring holds RING_WORDS full words between a partial front word and a
// partial back word. A pop or peek of more bits than held, or a push that
// would complete a word into a full ring, returns ok low and changes nothing.
// Reset (rst, synchronous) empties the FIFO; ring contents are not cleared
// and need no clearing pass. The receiver cannot stall: each result is
// presented for exactly one cycle.
module variable_width_bit_fifo_top
  import vwbf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [2:0]             opcode,
  input  logic [31:0]            push_data,
  input  logic [5:0]             bit_count,
  output logic                   busy,
  output logic                   done,
  output logic [31:0]            read_data,
  output logic                   ok,
  output logic [BITS_HELD_W-1:0] bits_held
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t     state;
  logic [2:0] op_q;
  word_t      data_q;
  logic [5:0] n_q;

  addr_t  ring_head, ring_head_next;
  addr_t  ring_tail, ring_tail_next;
  count_t ring_count, ring_count_next;
  word_t  front_word, front_word_next;
  logic [4:0] front_bits, front_bits_next;
  word_t  back_word, back_word_next;
  logic [4:0] back_bits, back_bits_next;

  word_t  read_data_next;
  logic   ok_next;
  held_t  held_now, held_next;

  logic   accept;
  logic   mem_we;
  word_t  mem_wdata;
  word_t  mem_rdata;

  logic       push_en;
  logic [5:0] push_n;
  word_t      push_word;
  logic [6:0] push_sum;
  logic [5:0] rem;
  word_t      src;
  logic       take;

  assign busy   = (state == S_EXEC);
  assign accept = start && !busy;

  vwbf_ram #(
    .WIDTH (WORD_W),
    .DEPTH (RING_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (ring_tail),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (ring_head),
    .rdata (mem_rdata)
  );

  assign held_now = (held_t'(ring_count) << 5) + held_t'(front_bits) + held_t'(back_bits);
  assign held_next = (held_t'(ring_count_next) << 5) + held_t'(front_bits_next)
                   + held_t'(back_bits_next);

  always_comb begin
    ring_head_next  = ring_head;
    ring_tail_next  = ring_tail;
    ring_count_next = ring_count;
    front_word_next = front_word;
    front_bits_next = front_bits;
    back_word_next  = back_word;
    back_bits_next  = back_bits;
    read_data_next  = '0;
    ok_next         = 1'b0;
    mem_we          = 1'b0;
    push_en         = 1'b0;
    push_n          = n_q;
    push_word       = data_q & low_mask(n_q);
    push_sum        = '0;
    rem             = n_q - {1'b0, front_bits};
    src             = (ring_count != '0) ? mem_rdata : back_word;
    take            = (op_q == OP_POP);

    unique case (op_q) inside
      OP_PUSH: begin
        push_en = 1'b1;
      end
      OP_POP, OP_PEEK: begin
        if (n_q <= {1'b0, front_bits}) begin
          ok_next        = 1'b1;
          read_data_next = front_word & low_mask(n_q);
          if (take) begin
            front_word_next = shr32(front_word, n_q);
            front_bits_next = front_bits - n_q[4:0];
          end
        end else if (held_t'(n_q) <= held_now) begin
          ok_next        = 1'b1;
          read_data_next = (front_word & low_mask({1'b0, front_bits}))
                         | shl32(src & low_mask(rem), {1'b0, front_bits});
          if (take) begin
            if (ring_count != '0) begin
              front_word_next = shr32(src, rem);
              front_bits_next = 5'(6'd32 - rem);
              ring_head_next  = ring_next(ring_head);
              ring_count_next = ring_count - count_t'(1);
            end else begin
              front_word_next = '0;
              front_bits_next = '0;
              back_word_next  = shr32(back_word, rem);
              back_bits_next  = back_bits - rem[4:0];
            end
          end
        end
      end
      OP_CLEAR: begin
        ok_next         = 1'b1;
        ring_head_next  = '0;
        ring_tail_next  = '0;
        ring_count_next = '0;
        front_word_next = '0;
        front_bits_next = '0;
        back_word_next  = '0;
        back_bits_next  = '0;
      end
      OP_PAD: begin
        if (back_bits[2:0] != 3'd0) begin
          push_en   = 1'b1;
          push_n    = 6'(4'd8 - {1'b0, back_bits[2:0]});
          push_word = '0;
        end else begin
          ok_next = 1'b1;
        end
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase

    // A push either fits in the back word, completes a word into the ring, or is refused when the ring is full.
    push_sum  = {2'b00, back_bits} + {1'b0, push_n};
    mem_wdata = back_word | shl32(push_word, {1'b0, back_bits});
    if (push_en) begin
      if (push_sum < 7'd32) begin
        ok_next        = 1'b1;
        back_word_next = mem_wdata;
        back_bits_next = push_sum[4:0];
      end else if (ring_count != count_t'(RING_WORDS)) begin
        ok_next         = 1'b1;
        mem_we          = 1'b1;
        ring_tail_next  = ring_next(ring_tail);
        ring_count_next = ring_count + count_t'(1);
        back_word_next  = shr32(push_word, 6'd32 - {1'b0, back_bits});
        back_bits_next  = push_sum[4:0];
      end
    end

    if (!ok_next) begin
      ring_head_next  = ring_head;
      ring_tail_next  = ring_tail;
      ring_count_next = ring_count;
      front_word_next = front_word;
      front_bits_next = front_bits;
      back_word_next  = back_word;
      back_bits_next  = back_bits;
      read_data_next  = '0;
      mem_we          = 1'b0;
    end
    if (state != S_EXEC) begin
      mem_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      ring_head  <= '0;
      ring_tail  <= '0;
      ring_count <= '0;
      front_word <= '0;
      front_bits <= '0;
      back_word  <= '0;
      back_bits  <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q   <= opcode;
            data_q <= push_data;
            n_q    <= (bit_count > 6'd32) ? 6'd32 : bit_count;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          ring_head  <= ring_head_next;
          ring_tail  <= ring_tail_next;
          ring_count <= ring_count_next;
          front_word <= front_word_next;
          front_bits <= front_bits_next;
          back_word  <= back_word_next;
          back_bits  <= back_bits_next;
          read_data  <= read_data_next;
          ok         <= ok_next;
          bits_held  <= BITS_HELD_W'(held_next);
          done       <= 1'b1;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
